// ===== design/gselect_branch_predictor_defines.svh =====
// ----------------------------------------------------------------------------
// gselect_branch_predictor_defines.svh
// Assertion macros shared by the predictor's checker.
// ----------------------------------------------------------------------------
`ifndef GSELECT_BRANCH_PREDICTOR_DEFINES_SVH
`define GSELECT_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Widths, register indexes and reset values of the gselect predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package gbp_pkg;

  localparam int ADDR_W     = 32;
  localparam int HIST_W     = 11;
  localparam int MOD_W      = 11;
  localparam int NB_W       = 4;
  localparam int CTR_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W      = 5;
  localparam int MAX_NB     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_BITS  = 2'd1;

  localparam logic [MOD_W-1:0] RST_INDEX_MODULUS = 11'd1024;
  localparam logic [NB_W-1:0]  RST_COUNTER_BITS  = 4'd2;

endpackage

`default_nettype wire

// ===== design/gbp_serial_mod.sv =====
// ----------------------------------------------------------------------------
// gbp_serial_mod
// Bit-serial restoring remainder: one dividend bit per cycle while en is high, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_serial_mod #(
  parameter int DIV_W = 11
) (
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             en,
  input  wire logic             bit_in,
  input  wire logic [DIV_W-1:0] divisor,
  output logic      [DIV_W-1:0] rem
);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // Remainder stays below the divisor, so one compare and subtract per bit.
  always_comb begin
    trial = {rem_r, bit_in};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = diff[DIV_W-1:0];
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      rem_r <= '0;
    end else if (en) begin
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule

`default_nettype wire

// ===== design/gbp_ctr_table.sv =====
// ----------------------------------------------------------------------------
// gbp_ctr_table
// Counter memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_ctr_table #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire logic [gbp_pkg::CTR_W-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [IDX_W-1:0]        rd_addr,
  output logic      [gbp_pkg::CTR_W-1:0] rd_data
);

  logic [gbp_pkg::CTR_W-1:0] mem [DEPTH];
  logic [gbp_pkg::CTR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/gselect_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// gselect_branch_predictor
// Global-history branch predictor with a table of saturating counters.
// ----------------------------------------------------------------------------
// Use: raise start with in_address and in_taken while busy is low; the beat is
// taken on that edge and busy rises. The address is reduced modulo
// index_modulus one bit per cycle (history reduced alongside), the folded
// sum is then reduced modulo the table depth one bit per cycle, and the
// counter is read and written back. out_predicted_taken is shown with
// out_valid for exactly one cycle, and busy drops in that same cycle, so no
// new beat is taken while an item is still in flight.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index
// (0 index_modulus, 1 counter_bits); cfg_ready is always high. Write only
// while busy is low and no result is pending.
// Reset: history clears, registers take their defaults, then a clearing pass
// writes 1 into every counter, one entry a cycle, with busy high. The
// receiver cannot stall: a result is lost if not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gselect_branch_predictor #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [gbp_pkg::ADDR_W-1:0]      in_address,
  input  wire logic                            in_taken,
  output logic                                 out_valid,
  output logic                                 out_predicted_taken,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SHIFT,
    S_LOAD,
    S_SUM,
    S_READ,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;

  logic [gbp_pkg::CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]           clr_idx_r;
  logic [gbp_pkg::MOD_W-1:0]  index_modulus_r;
  logic [gbp_pkg::NB_W-1:0]   counter_bits_r;
  logic [gbp_pkg::HIST_W-1:0] history_r;
  logic                       out_valid_r;
  logic                       out_pred_r;

  logic [gbp_pkg::ADDR_W-1:0] addr_sr_r;
  logic [gbp_pkg::HIST_W-1:0] hist_sr_r;
  logic [gbp_pkg::MOD_W-1:0]  sum_sr_r;
  logic                       taken_r;

  logic                       accept;
  logic                       last_addr_bit;
  logic                       last_sum_bit;
  logic                       hist_en;
  logic [gbp_pkg::MOD_W-1:0]  m_eff;
  logic [gbp_pkg::NB_W-1:0]   n_eff;
  logic [gbp_pkg::MOD_W-1:0]  addr_rem;
  logic [gbp_pkg::MOD_W-1:0]  hist_rem;
  logic [DEPTH_W-1:0]         idx_rem;
  logic [IDX_W-1:0]           idx;
  logic [gbp_pkg::MOD_W-1:0]  sum;
  logic [gbp_pkg::CTR_W-1:0]  thr;
  logic [gbp_pkg::CTR_W-1:0]  top;
  logic [gbp_pkg::CTR_W-1:0]  val;
  logic [gbp_pkg::CTR_W:0]    inc;
  logic [gbp_pkg::CTR_W-1:0]  val_new;
  logic                       pred;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [gbp_pkg::CTR_W-1:0]  wr_data;

  assign accept        = start && (state_r == S_IDLE);
  assign last_addr_bit = (cnt_r == gbp_pkg::CNT_W'(gbp_pkg::ADDR_W - 1));
  assign last_sum_bit  = (cnt_r == gbp_pkg::CNT_W'(gbp_pkg::MOD_W - 1));
  assign hist_en       = (state_r == S_SHIFT) && (cnt_r < gbp_pkg::CNT_W'(gbp_pkg::HIST_W));

  // A zero modulus acts as one; the counter width is held to 1..8.
  always_comb begin
    m_eff = (index_modulus_r == '0) ? gbp_pkg::MOD_W'(1) : index_modulus_r;
    if (counter_bits_r == '0) begin
      n_eff = gbp_pkg::NB_W'(1);
    end else if (counter_bits_r > gbp_pkg::NB_W'(gbp_pkg::MAX_NB)) begin
      n_eff = gbp_pkg::NB_W'(gbp_pkg::MAX_NB);
    end else begin
      n_eff = counter_bits_r;
    end
    thr = gbp_pkg::CTR_W'(1) << (n_eff - gbp_pkg::NB_W'(1));
    top = thr << 1;
  end

  assign sum = {1'b0, addr_rem[gbp_pkg::MOD_W-1:1]} + {1'b0, hist_rem[gbp_pkg::MOD_W-1:1]};
  assign idx = idx_rem[IDX_W-1:0];

  gbp_serial_mod #(.DIV_W(gbp_pkg::MOD_W)) u_addr_mod (
    .clk     (clk),
    .clr     (accept),
    .en      (state_r == S_SHIFT),
    .bit_in  (addr_sr_r[gbp_pkg::ADDR_W-1]),
    .divisor (m_eff),
    .rem     (addr_rem)
  );

  gbp_serial_mod #(.DIV_W(gbp_pkg::MOD_W)) u_hist_mod (
    .clk     (clk),
    .clr     (accept),
    .en      (hist_en),
    .bit_in  (hist_sr_r[gbp_pkg::HIST_W-1]),
    .divisor (m_eff),
    .rem     (hist_rem)
  );

  gbp_serial_mod #(.DIV_W(DEPTH_W)) u_idx_mod (
    .clk     (clk),
    .clr     (state_r == S_LOAD),
    .en      (state_r == S_SUM),
    .bit_in  (sum_sr_r[gbp_pkg::MOD_W-1]),
    .divisor (DEPTH_W'(TABLE_DEPTH)),
    .rem     (idx_rem)
  );

  // Counter update from the value read at the index.
  always_comb begin
    pred = (val > thr);
    inc  = {1'b0, val} + (gbp_pkg::CTR_W+1)'(1);
    if (taken_r) begin
      val_new = (inc > {1'b0, top}) ? top : inc[gbp_pkg::CTR_W-1:0];
    end else begin
      val_new = (val > gbp_pkg::CTR_W'(1)) ? (val - gbp_pkg::CTR_W'(1))
                                           : gbp_pkg::CTR_W'(1);
    end
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = gbp_pkg::CTR_W'(1);
    end else begin
      wr_en   = (state_r == S_UPDATE);
      wr_addr = idx;
      wr_data = val_new;
    end
  end

  gbp_ctr_table #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state_r == S_READ),
    .rd_addr (idx),
    .rd_data (val)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_idx_r == IDX_W'(TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (start) state_nxt = S_SHIFT;
      S_SHIFT:  if (last_addr_bit) state_nxt = S_LOAD;
      S_LOAD:   state_nxt = S_SUM;
      S_SUM:    if (last_sum_bit) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      cnt_r           <= '0;
      clr_idx_r       <= '0;
      index_modulus_r <= gbp_pkg::RST_INDEX_MODULUS;
      counter_bits_r  <= gbp_pkg::RST_COUNTER_BITS;
      history_r       <= '0;
      out_valid_r     <= 1'b0;
      out_pred_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_UPDATE);
      if (state_r == S_UPDATE) begin
        out_pred_r <= pred;
        history_r  <= {hist_rem[gbp_pkg::MOD_W-1:1], taken_r};
      end
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      // Reuse the bit counter for both serial passes.
      if ((state_r == S_SHIFT) || (state_r == S_SUM)) begin
        cnt_r <= cnt_r + gbp_pkg::CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          gbp_pkg::REG_INDEX_MODULUS: index_modulus_r <= cfg_data;
          gbp_pkg::REG_COUNTER_BITS:  counter_bits_r  <= cfg_data[gbp_pkg::NB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Shift lines: load on accept (sum in S_LOAD), one bit per cycle in a pass.
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_sr_r <= in_address;
      hist_sr_r <= history_r;
      taken_r   <= in_taken;
    end else begin
      if (state_r == S_SHIFT) begin
        addr_sr_r <= addr_sr_r << 1;
      end
      if (hist_en) begin
        hist_sr_r <= hist_sr_r << 1;
      end
    end
    if (state_r == S_LOAD) begin
      sum_sr_r <= sum;
    end else if (state_r == S_SUM) begin
      sum_sr_r <= sum_sr_r << 1;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_pred_r;
  assign cfg_ready           = 1'b1;

endmodule

`default_nettype wire

// ===== design/gbp_checker.sv =====
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks on the predictor's command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gselect_branch_predictor_defines.svh"

module gbp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  `GBP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `GBP_ASSERT_NXT(a_strobe_one, out_valid, !out_valid, "result strobe held past one cycle")
  `GBP_ASSERT_IMP(a_result_idle, out_valid, !busy, "result shown while still busy")
  `GBP_ASSERT_IMP(a_result_after, out_valid, $past(busy), "result without a preceding item")

endmodule

bind gselect_branch_predictor gbp_checker u_gbp_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gselect branch predictor: a short table of
// directed branches and register writes, then phases of random branch
// streams under varied modulus and counter widths, each prediction checked
// against an in-bench model of the history register and counter table, or a fixed expected value.
// ----------------------------------------------------------------------------

module tb;

  localparam int TBL_DEPTH  = 1024;
  localparam int LATENCY    = 46;
  localparam int WDOG_LIMIT = 4 * TBL_DEPTH + 2000;
  localparam int NUM_DIR    = 26;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_LEN  = 160;
  localparam int MAX_PRINTS = 40;

  localparam logic [gbp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic TAKEN     = 1'b1;
  localparam logic NOT_TAKEN = 1'b0;

  typedef struct packed {
    logic                           is_cfg;
    logic [gbp_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [gbp_pkg::CFG_DATA_W-1:0] wdata;
    logic [gbp_pkg::ADDR_W-1:0]     addr;
    logic                           tk;
    logic                           has_exp;
    logic                           exp_val;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [gbp_pkg::ADDR_W-1:0]     in_address = '0;
  logic                           in_taken = 1'b0;
  logic                           out_valid;
  logic                           out_predicted_taken;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // bench copy of the block state
  logic [gbp_pkg::MOD_W-1:0]  mod_reg;
  logic [gbp_pkg::NB_W-1:0]   nbits_reg;
  logic [gbp_pkg::HIST_W-1:0] ghist;
  logic [gbp_pkg::CTR_W-1:0]  ctr_tbl [TBL_DEPTH];

  logic pred_dir_q [$];
  logic want_dir;
  int   mismatches = 0;
  int   results_seen = 0;
  int   wdog = 0;

  step_t dir_steps [0:NUM_DIR-1];

  gselect_branch_predictor #(.TABLE_DEPTH(TBL_DEPTH)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_address          (in_address),
    .in_taken            (in_taken),
    .out_valid           (out_valid),
    .out_predicted_taken (out_predicted_taken),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic step_t brn(input logic [gbp_pkg::ADDR_W-1:0] a, input logic tk,
                                input logic has, input logic ev);
    step_t s;
    s = '0;
    s.addr = a;
    s.tk = tk;
    s.has_exp = has;
    s.exp_val = ev;
    return s;
  endfunction

  function automatic step_t wr(input logic [gbp_pkg::CFG_IDX_W-1:0] idx,
                               input logic [gbp_pkg::CFG_DATA_W-1:0] d);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.wdata = d;
    return s;
  endfunction

  // Predict from the counter, then train history and counter with the outcome.
  function automatic logic predict_direction(input logic [gbp_pkg::ADDR_W-1:0] addr,
                                             input logic tk);
    int unsigned m, n, thr, top, h, idx, val;
    logic pred;
    m = (mod_reg == 0) ? 1 : mod_reg;
    n = nbits_reg;
    if (n < 1) n = 1;
    if (n > gbp_pkg::MAX_NB) n = gbp_pkg::MAX_NB;
    thr = 1 << (n - 1);
    top = thr * 2;
    h = (ghist % m) / 2;
    idx = ((addr % m) / 2 + h) % TBL_DEPTH;
    val = ctr_tbl[idx];
    pred = (val > thr);
    if (tk) begin
      ghist = gbp_pkg::HIST_W'(2 * h + 1);
      val = val + 1;
      if (val > top) val = top;
    end else begin
      ghist = gbp_pkg::HIST_W'(2 * h);
      val = (val > 1) ? val - 1 : 1;
    end
    ctr_tbl[idx] = gbp_pkg::CTR_W'(val);
    return pred;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_branch(input logic [gbp_pkg::ADDR_W-1:0] a, input logic tk,
                             input logic has_exp, input logic exp_val, input int gap);
    logic guess;
    start      <= 1'b1;
    in_address <= a;
    in_taken   <= tk;
    cfg_valid  <= 1'b0;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    guess = predict_direction(a, tk);
    pred_dir_q.push_back(has_exp ? exp_val : guess);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write only once every prediction is back and the block is idle.
  task automatic write_reg(input logic [gbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gbp_pkg::CFG_DATA_W-1:0] d);
    start <= 1'b0;
    while (pred_dir_q.size() != 0 || busy !== 1'b0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == gbp_pkg::REG_INDEX_MODULUS) mod_reg = d[gbp_pkg::MOD_W-1:0];
    else if (idx == gbp_pkg::REG_COUNTER_BITS) nbits_reg = d[gbp_pkg::NB_W-1:0];
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (pred_dir_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no prediction pending", results_seen));
      end else begin
        want_dir = pred_dir_q.pop_front();
        if (out_predicted_taken !== want_dir)
          report_mismatch($sformatf("result %0d: predicted_taken %b, expected %b",
                                    results_seen, out_predicted_taken, want_dir));
      end
    end
  end

  // Count cycles with no beat on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1 ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        wdog <= 0;
      end else if (wdog >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        wdog <= wdog + 1;
      end
    end
  end

  initial begin
    int ph, i, k, gap;
    logic burst, tk;
    logic [gbp_pkg::ADDR_W-1:0] a;
    logic [gbp_pkg::MOD_W-1:0] mod_w;
    logic [gbp_pkg::NB_W-1:0] nb_w;
    logic [gbp_pkg::CFG_DATA_W-1:0] wdata;
    logic [gbp_pkg::ADDR_W-1:0] pool_addr [4];
    int unsigned pool_bias [4];

    mod_reg = gbp_pkg::RST_INDEX_MODULUS;
    nbits_reg = gbp_pkg::RST_COUNTER_BITS;
    ghist = '0;
    for (i = 0; i < TBL_DEPTH; i++) ctr_tbl[i] = gbp_pkg::CTR_W'(1);

    dir_steps = '{
      // fresh table: every counter sits at one, so nothing predicts taken
      brn(32'h0000_0000, NOT_TAKEN, 1'b1, NOT_TAKEN),
      brn(32'hFFFF_FFFF, TAKEN,     1'b1, NOT_TAKEN),
      brn(32'hFFFF_FFFF, TAKEN,     1'b0, 1'b0),
      brn(32'hFFFF_FFFF, TAKEN,     1'b0, 1'b0),
      brn(32'hFFFF_FFFF, TAKEN,     1'b0, 1'b0),
      brn(32'h8000_0000, NOT_TAKEN, 1'b0, 1'b0),
      brn(32'hAAAA_5555, TAKEN,     1'b0, 1'b0),
      brn(32'h5555_AAAA, NOT_TAKEN, 1'b0, 1'b0),
      wr(REG_SPARE, 11'h7FF),
      // width field reads zero, upper data bits set
      wr(gbp_pkg::REG_COUNTER_BITS, 11'h7F0),
      brn(32'hFFFF_FFFF, TAKEN,     1'b0, 1'b0),
      brn(32'hFFFF_FFFF, NOT_TAKEN, 1'b0, 1'b0),
      // zero modulus folds every branch onto entry zero
      wr(gbp_pkg::REG_INDEX_MODULUS, 11'd0),
      wr(gbp_pkg::REG_COUNTER_BITS, 11'd15),
      brn(32'h0000_0001, TAKEN,     1'b0, 1'b0),
      brn(32'h7FFF_FFFF, TAKEN,     1'b0, 1'b0),
      brn(32'hDEAD_0000, TAKEN,     1'b0, 1'b0),
      brn(32'h0000_BEEF, TAKEN,     1'b0, 1'b0),
      // narrow the counter while entry zero sits above the new ceiling
      wr(gbp_pkg::REG_COUNTER_BITS, 11'd1),
      brn(32'h1234_5678, NOT_TAKEN, 1'b0, 1'b0),
      brn(32'hFFFF_FFFF, TAKEN,     1'b0, 1'b0),
      wr(gbp_pkg::REG_INDEX_MODULUS, 11'd2047),
      brn(32'hFFFF_FFFF, TAKEN,     1'b0, 1'b0),
      brn(32'h0000_07FE, NOT_TAKEN, 1'b0, 1'b0),
      wr(gbp_pkg::REG_INDEX_MODULUS, 11'd2),
      brn(32'hFFFF_FFFE, TAKEN,     1'b0, 1'b0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIR; i++) begin
      if (dir_steps[i].is_cfg)
        write_reg(dir_steps[i].reg_idx, dir_steps[i].wdata);
      else
        send_branch(dir_steps[i].addr, dir_steps[i].tk, dir_steps[i].has_exp,
                    dir_steps[i].exp_val, $urandom_range(0, 14));
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          mod_w = 11'd1024;
          nb_w = 4'd8;
        end
        1: begin
          mod_w = 11'd2;
          nb_w = 4'd1;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: mod_w = gbp_pkg::MOD_W'($urandom_range(2, 1024));
            1: mod_w = gbp_pkg::MOD_W'($urandom_range(2, 40));
            2: mod_w = gbp_pkg::MOD_W'(1 << $urandom_range(2, 10));
            default: mod_w = gbp_pkg::MOD_W'($urandom_range(0, 2047));
          endcase
          if ($urandom_range(0, 4) == 0) nb_w = gbp_pkg::NB_W'($urandom_range(0, 15));
          else nb_w = gbp_pkg::NB_W'($urandom_range(1, gbp_pkg::MAX_NB));
        end
      endcase
      wdata = gbp_pkg::CFG_DATA_W'($urandom());
      wdata[gbp_pkg::NB_W-1:0] = nb_w;
      if ($urandom_range(0, 1)) begin
        write_reg(gbp_pkg::REG_INDEX_MODULUS, mod_w);
        write_reg(gbp_pkg::REG_COUNTER_BITS, wdata);
      end else begin
        write_reg(gbp_pkg::REG_COUNTER_BITS, wdata);
        write_reg(gbp_pkg::REG_INDEX_MODULUS, mod_w);
      end

      // a handful of hot branches, each with its own taken bias
      for (k = 0; k < 4; k++) begin
        pool_addr[k] = $urandom();
        pool_bias[k] = $urandom_range(0, 8);
      end
      burst = (ph % 3 == 2);

      for (i = 0; i < PHASE_LEN; i++) begin
        if ($urandom_range(0, 9) < 8) begin
          k = $urandom_range(0, 3);
          a = pool_addr[k];
          tk = ($urandom_range(0, 7) < pool_bias[k]);
        end else begin
          a = $urandom();
          tk = 1'($urandom_range(0, 1));
        end
        gap = burst ? 0 : $urandom_range(0, 14);
        send_branch(a, tk, 1'b0, 1'b0, gap);
      end
    end

    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (pred_dir_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/gbp_pkg.sv
design/gbp_serial_mod.sv
design/gbp_ctr_table.sv
design/gselect_branch_predictor.sv
design/gbp_checker.sv
tb/sv/tb.sv
